[rtl/tbm_pkg.sv]
// Shared types and constants of the thermistor bank monitor.
`default_nettype none

package tbm_pkg;

  localparam int NUM_BANKS      = 3;
  localparam int SLOTS_PER_BANK = 8;
  localparam int SCAN_LEN       = NUM_BANKS * SLOTS_PER_BANK;
  localparam int POS_W          = 5;
  localparam int BANK_W         = 2;
  localparam int SLOT_W         = 3;
  localparam int CODE_W         = 25;
  localparam int FLAG_W         = 8;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;

  localparam logic [SLOT_W-1:0] REF_SLOT        = SLOT_W'(7);
  localparam logic [POS_W-1:0]  LAST_SENSOR_POS = POS_W'(20);
  localparam logic [POS_W-1:0]  LAST_POS        = POS_W'(SCAN_LEN - 1);

  localparam logic [CODE_W-1:0] HOT_LIMIT_RST  = CODE_W'(32'h0044_4952);
  localparam logic [CODE_W-1:0] OPEN_LIMIT_RST = CODE_W'(32'h00B0_0000);
  localparam logic [CODE_W-1:0] REF_LIMIT_RST  = CODE_W'(32'h00F5_C28F);

  // Register indexes on the configuration port (byte address is four times this).
  localparam logic [1:0] REG_HOT_LIMIT  = 2'd0;
  localparam logic [1:0] REG_OPEN_LIMIT = 2'd1;
  localparam logic [1:0] REG_REF_LIMIT  = 2'd2;
  localparam logic [1:0] REG_STICKY     = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] hot_limit;
    logic [CODE_W-1:0] open_limit;
    logic [CODE_W-1:0] ref_limit;
    logic              sticky;
  } tbm_cfg_t;

  typedef struct packed {
    logic [NUM_BANKS-1:0][FLAG_W-1:0] flags;
    logic [FLAG_W-1:0]                any_flags;
    logic [CODE_W-1:0]                max_reading;
    logic [POS_W-1:0]                 max_position;
  } tbm_result_t;

endpackage

`default_nettype wire

[rtl/tbm_apb_regs.sv]
// Configuration registers of the thermistor bank monitor behind an APB-style port.
`default_nettype none

module tbm_apb_regs
  import tbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output tbm_cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hot_limit  <= HOT_LIMIT_RST;
      cfg.open_limit <= OPEN_LIMIT_RST;
      cfg.ref_limit  <= REF_LIMIT_RST;
      cfg.sticky     <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HOT_LIMIT:  cfg.hot_limit  <= pwdata[CODE_W-1:0];
        REG_OPEN_LIMIT: cfg.open_limit <= pwdata[CODE_W-1:0];
        REG_REF_LIMIT:  cfg.ref_limit  <= pwdata[CODE_W-1:0];
        REG_STICKY:     cfg.sticky     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HOT_LIMIT:  prdata = DATA_W'(cfg.hot_limit);
      REG_OPEN_LIMIT: prdata = DATA_W'(cfg.open_limit);
      REG_REF_LIMIT:  prdata = DATA_W'(cfg.ref_limit);
      REG_STICKY:     prdata = DATA_W'(cfg.sticky);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/tbm_scan_core.sv]
// Scan state of the thermistor bank monitor: position, running maximum and flag bytes.
`default_nettype none

module tbm_scan_core
  import tbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire logic [CODE_W-1:0] reading,
  input  wire logic              restart,
  input  wire tbm_cfg_t          cfg,
  output logic                   at_last,
  output logic                   done,
  output tbm_result_t            result
);

  logic [POS_W-1:0]                 scan_position;
  logic [POS_W-1:0]                 scan_position_next;
  logic [CODE_W-1:0]                running_max;
  logic [POS_W-1:0]                 running_max_pos;
  logic [NUM_BANKS-1:0][FLAG_W-1:0] bank_flags;

  logic [POS_W-1:0]                 pos;
  logic [BANK_W-1:0]                bank;
  logic [SLOT_W-1:0]                slot;
  logic                             scan_start;
  logic                             is_ref;
  logic                             is_sensor;
  logic                             flag_hit;
  logic [CODE_W-1:0]                base_max;
  logic [POS_W-1:0]                 base_pos;
  logic [NUM_BANKS-1:0][FLAG_W-1:0] flags_next;

  assign at_last = (scan_position == LAST_POS);

  always_comb begin
    pos        = restart ? '0 : scan_position;
    bank       = pos[POS_W-1:SLOT_W];
    slot       = pos[SLOT_W-1:0];
    scan_start = (pos == '0);
    is_ref     = (slot == REF_SLOT);
    is_sensor  = !is_ref && (pos <= LAST_SENSOR_POS);
    done       = (pos == LAST_POS);

    base_max   = scan_start ? '0 : running_max;
    base_pos   = scan_start ? '0 : running_max_pos;
    flags_next = (scan_start && !cfg.sticky) ? '0 : bank_flags;

    flag_hit = is_ref ? (reading <= cfg.ref_limit)
                      : (is_sensor && ((reading <= cfg.hot_limit) ||
                                       (reading > cfg.open_limit)));

    result.max_reading  = base_max;
    result.max_position = base_pos;
    if (is_sensor && (reading > base_max)) begin
      result.max_reading  = reading;
      result.max_position = pos;
    end

    for (int b = 0; b < NUM_BANKS; b++) begin
      if (flag_hit && (bank == BANK_W'(b))) begin
        flags_next[b][slot] = 1'b1;
      end
    end

    result.flags     = flags_next;
    result.any_flags = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      result.any_flags = result.any_flags | flags_next[b];
    end

    scan_position_next = done ? '0 : pos + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position   <= '0;
      running_max     <= '0;
      running_max_pos <= '0;
      bank_flags      <= '0;
    end else if (go) begin
      scan_position   <= scan_position_next;
      running_max     <= result.max_reading;
      running_max_pos <= result.max_position;
      bank_flags      <= flags_next;
    end
  end

  a_pos_in_range : assert property (@(posedge clk) disable iff (rst)
    scan_position <= LAST_POS)
    else $error("scan position ran past the end of the scan");

  a_pos_steps : assert property (@(posedge clk) disable iff (rst)
    go && !restart && !at_last |=> scan_position == $past(scan_position) + POS_W'(1))
    else $error("scan position did not advance by one");

  a_wrap_on_done : assert property (@(posedge clk) disable iff (rst)
    go && done |=> scan_position == '0)
    else $error("scan position did not wrap after the last reading");

endmodule

`default_nettype wire

[rtl/thermistor_bank_monitor.sv]
// Top level of the thermistor bank monitor: input stage, scan core and result register.
// Path: an accepted reading is registered in the input register and then folded into the
//   scan state; the reading that closes a scan also loads the result word register.
// Throughput: one reading per cycle; the input stalls only when the last reading of a scan
//   waits in the input register while the previous result word is still held off.
// Reset (rst, synchronous, active high) empties both stages, restarts the scan at
//   position zero, clears the maximum and flags, and reloads the limit registers.
`default_nettype none

module thermistor_bank_monitor
  import tbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // Reading channel.
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CODE_W-1:0] reading,
  input  wire logic              restart,
  // Result channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [FLAG_W-1:0] bank0_flags,
  output logic      [FLAG_W-1:0] bank1_flags,
  output logic      [FLAG_W-1:0] bank2_flags,
  output logic      [FLAG_W-1:0] any_flags,
  output logic      [CODE_W-1:0] max_reading,
  output logic      [POS_W-1:0]  max_position,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  tbm_cfg_t          cfg;
  tbm_result_t       scan_result;
  tbm_result_t       result_q;

  // Input register: one reading word waiting to be folded into the scan state.
  logic              s1_valid;
  logic [CODE_W-1:0] s1_reading;
  logic              s1_restart;
  logic              s1_blocked;
  logic              s1_go;
  logic              at_last;
  logic              done;
  logic              out_take;
  logic              in_take;

  tbm_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbm_scan_core u_core (
    .clk     (clk),
    .rst     (rst),
    .go      (s1_go),
    .reading (s1_reading),
    .restart (s1_restart),
    .cfg     (cfg),
    .at_last (at_last),
    .done    (done),
    .result  (scan_result)
  );

  // Only the reading that closes a scan needs room in the result register; every
  // other reading goes straight into the scan state. The check uses registered
  // signals and out_stall alone, so the stall has no path from the input payload.
  assign out_take   = out_valid && !out_stall;
  assign s1_blocked = s1_valid && !s1_restart && at_last && out_valid && out_stall;
  assign s1_go      = s1_valid && !s1_blocked;
  assign in_stall   = s1_blocked;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_blocked) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_reading <= reading;
      s1_restart <= restart;
    end
  end

  // Result register: loaded when the last reading of a scan is processed, which can
  // only happen when it is empty or being emptied in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && done) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && done) begin
      result_q <= scan_result;
    end
  end

  assign bank0_flags  = result_q.flags[0];
  assign bank1_flags  = result_q.flags[1];
  assign bank2_flags  = result_q.flags[2];
  assign any_flags    = result_q.any_flags;
  assign max_reading  = result_q.max_reading;
  assign max_position = result_q.max_position;

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !(s1_go && done))
    else $error("a held result word would be overwritten");

  a_blocked_holds : assert property (@(posedge clk) disable iff (rst)
    s1_blocked |=> s1_valid && $stable(s1_reading) && $stable(s1_restart))
    else $error("a blocked reading left the input register");

  a_any_is_or : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> any_flags == (bank0_flags | bank1_flags | bank2_flags))
    else $error("combined flags disagree with the bank flags");

endmodule

`default_nettype wire
